[rtl/sha256md_pkg.sv]
package sha256md_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       message_end;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_number;
      logic        final_word;
   } rsp_type;

   localparam logic [1:0] BSEL_DATA = 2'd0;
   localparam logic [1:0] BSEL_PAD  = 2'd1;
   localparam logic [1:0] BSEL_ZERO = 2'd2;
   localparam logic [1:0] BSEL_LEN  = 2'd3;

   localparam logic [5:0] FILL_LAST = 6'd63;
   localparam logic [5:0] FILL_LEN  = 6'd56;
   localparam logic [2:0] WORD_LAST = 3'd7;
   localparam logic [5:0] ROUND_LAST = 6'd63;
   localparam logic [7:0] PAD_BYTE  = 8'h80;

   typedef struct packed {
      logic       byte_wr;
      logic [1:0] byte_sel;
      logic       count_bytes;
      logic       clear_len;
      logic       load_vars;
      logic       round_en;
      logic [5:0] round_idx;
      logic       chain_add;
      logic       emit_shift;
      logic [2:0] emit_idx;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
   } sts_type;

   function automatic logic [31:0] sha_iv(input logic [2:0] idx);
      logic [31:0] v;
      case (idx)
         3'd0: v = 32'h6a09e667;
         3'd1: v = 32'hbb67ae85;
         3'd2: v = 32'h3c6ef372;
         3'd3: v = 32'ha54ff53a;
         3'd4: v = 32'h510e527f;
         3'd5: v = 32'h9b05688c;
         3'd6: v = 32'h1f83d9ab;
         default: v = 32'h5be0cd19;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] sha_k(input logic [5:0] idx);
      logic [31:0] v;
      case (idx)
         6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
         6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
         6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
         6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
         6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
         6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
         6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
         6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
         6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
         6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
         6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
         6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
         6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
         6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
         6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
         6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
         6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
         6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
         6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
         6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
         6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
         6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
         6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
         6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
         6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
         6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
         6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
         6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
         6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
         6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
         6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
         6'd62: v = 32'hbef9a3f7;
         default: v = 32'hc67178f2;
      endcase
      return v;
   endfunction

endpackage

[rtl/sha256md_dp.sv]
module sha256md_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  sha256md_pkg::req_type req_data,
   input  sha256md_pkg::cmd_type cmd,
   output sha256md_pkg::sts_type sts,
   output sha256md_pkg::rsp_type rsp_data
);
   import sha256md_pkg::*;

   logic [5:0]  fill_ff, fill_in;
   logic [60:0] msg_ff, msg_in;
   logic [23:0] acc_ff, acc_in;
   logic [31:0] win_ff [16];
   logic [31:0] win_in [16];
   logic [31:0] vars_ff [8];
   logic [31:0] vars_in [8];
   logic [31:0] chain_ff [8];
   logic [31:0] chain_in [8];

   logic [7:0]  wr_byte;
   logic [63:0] len_bits;
   logic [31:0] x15, x2, s0, s1, sched, new_w;
   logic [31:0] big_s0, big_s1, ch, maj, t1, t2;

   assign len_bits = {msg_ff, 3'b000} << {fill_ff[2:0], 3'b000};

   always_comb begin
      case (cmd.byte_sel)
         BSEL_DATA: wr_byte = req_data.data_byte;
         BSEL_PAD:  wr_byte = PAD_BYTE;
         BSEL_ZERO: wr_byte = 8'h00;
         BSEL_LEN:  wr_byte = len_bits[63:56];
         default:   wr_byte = 8'h00;
      endcase
   end

   assign x15   = win_ff[1];
   assign x2    = win_ff[14];
   assign s0    = {x15[6:0], x15[31:7]} ^ {x15[17:0], x15[31:18]} ^ (x15 >> 3);
   assign s1    = {x2[16:0], x2[31:17]} ^ {x2[18:0], x2[31:19]} ^ (x2 >> 10);
   assign sched = win_ff[0] + s0 + win_ff[9] + s1;
   assign new_w = (cmd.round_idx[5:4] == 2'b00) ? win_ff[0] : sched;

   assign big_s1 = {vars_ff[4][5:0], vars_ff[4][31:6]} ^ {vars_ff[4][10:0], vars_ff[4][31:11]}
                 ^ {vars_ff[4][24:0], vars_ff[4][31:25]};
   assign big_s0 = {vars_ff[0][1:0], vars_ff[0][31:2]} ^ {vars_ff[0][12:0], vars_ff[0][31:13]}
                 ^ {vars_ff[0][21:0], vars_ff[0][31:22]};
   assign ch  = (vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]);
   assign maj = (vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
              ^ (vars_ff[1] & vars_ff[2]);
   assign t1  = vars_ff[7] + big_s1 + ch + sha_k(cmd.round_idx) + new_w;
   assign t2  = big_s0 + maj;

   always_comb begin
      fill_in  = fill_ff;
      msg_in   = msg_ff;
      acc_in   = acc_ff;
      win_in   = win_ff;
      vars_in  = vars_ff;
      chain_in = chain_ff;

      if (cmd.byte_wr) begin
         fill_in = fill_ff + 6'd1;
         acc_in  = {acc_ff[15:0], wr_byte};
         if (fill_ff[1:0] == 2'b11) begin
            for (int j = 0; j < 15; j++) begin
               win_in[j] = win_ff[j + 1];
            end
            win_in[15] = {acc_ff, wr_byte};
         end
      end
      if (cmd.count_bytes) begin
         msg_in = msg_ff + 61'd1;
      end
      if (cmd.clear_len) begin
         msg_in = '0;
      end
      if (cmd.load_vars) begin
         vars_in = chain_ff;
      end
      if (cmd.round_en) begin
         for (int j = 0; j < 15; j++) begin
            win_in[j] = win_ff[j + 1];
         end
         win_in[15] = new_w;
         vars_in[7] = vars_ff[6];
         vars_in[6] = vars_ff[5];
         vars_in[5] = vars_ff[4];
         vars_in[4] = vars_ff[3] + t1;
         vars_in[3] = vars_ff[2];
         vars_in[2] = vars_ff[1];
         vars_in[1] = vars_ff[0];
         vars_in[0] = t1 + t2;
      end
      if (cmd.chain_add) begin
         for (int j = 0; j < 8; j++) begin
            chain_in[j] = chain_ff[j] + vars_ff[j];
         end
      end
      if (cmd.emit_shift) begin
         for (int j = 0; j < 7; j++) begin
            chain_in[j] = chain_ff[j + 1];
         end
         chain_in[7] = sha_iv(cmd.emit_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         msg_ff  <= '0;
         for (int j = 0; j < 8; j++) begin
            chain_ff[j] <= sha_iv(3'(j));
         end
      end else begin
         fill_ff  <= fill_in;
         msg_ff   <= msg_in;
         chain_ff <= chain_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      win_ff  <= win_in;
      vars_ff <= vars_in;
   end

   assign sts.fill             = fill_ff;
   assign rsp_data.digest_word = chain_ff[0];
   assign rsp_data.word_number = cmd.emit_idx;
   assign rsp_data.final_word  = (cmd.emit_idx == WORD_LAST);

endmodule

[rtl/sha256md_ctrl.sv]
module sha256md_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sha256md_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  sha256md_pkg::sts_type sts,
   output sha256md_pkg::cmd_type cmd
);
   import sha256md_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_ROUND = 3'd1;
   localparam logic [2:0] ST_ADD   = 3'd2;
   localparam logic [2:0] ST_PAD   = 3'd3;
   localparam logic [2:0] ST_LEN   = 3'd4;
   localparam logic [2:0] ST_EMIT  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [2:0] emit_ff, emit_in;
   logic       end_ff, end_in;
   logic       first_ff, first_in;
   logic       final_ff, final_in;

   always_comb begin
      state_in  = state_ff;
      rnd_in    = rnd_ff;
      emit_in   = emit_ff;
      end_in    = end_ff;
      first_in  = first_ff;
      final_in  = final_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      cmd.round_idx = rnd_ff;
      cmd.emit_idx  = emit_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               end_in   = req_data.message_end;
               first_in = req_data.message_end;
               if (req_data.byte_present) begin
                  cmd.byte_wr     = 1'b1;
                  cmd.byte_sel    = BSEL_DATA;
                  cmd.count_bytes = 1'b1;
                  if (sts.fill == FILL_LAST) begin
                     cmd.load_vars = 1'b1;
                     state_in      = ST_ROUND;
                  end else if (req_data.message_end) begin
                     state_in = ST_PAD;
                  end
               end else if (req_data.message_end) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            cmd.round_en = 1'b1;
            rnd_in       = rnd_ff + 6'd1;
            if (rnd_ff == ROUND_LAST) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.chain_add = 1'b1;
            if (final_ff) begin
               state_in = ST_EMIT;
            end else if (end_ff) begin
               state_in = ST_PAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_PAD: begin
            if (first_ff || sts.fill != FILL_LEN) begin
               cmd.byte_wr  = 1'b1;
               cmd.byte_sel = first_ff ? BSEL_PAD : BSEL_ZERO;
               first_in     = 1'b0;
               if (sts.fill == FILL_LAST) begin
                  cmd.load_vars = 1'b1;
                  state_in      = ST_ROUND;
               end
            end else begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            cmd.byte_wr  = 1'b1;
            cmd.byte_sel = BSEL_LEN;
            if (sts.fill == FILL_LAST) begin
               cmd.load_vars = 1'b1;
               final_in      = 1'b1;
               state_in      = ST_ROUND;
            end
         end
         ST_EMIT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               cmd.emit_shift = 1'b1;
               emit_in        = emit_ff + 3'd1;
               if (emit_ff == WORD_LAST) begin
                  cmd.clear_len = 1'b1;
                  final_in      = 1'b0;
                  end_in        = 1'b0;
                  state_in      = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rnd_ff   <= '0;
         emit_ff  <= '0;
         end_ff   <= 1'b0;
         first_ff <= 1'b0;
         final_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         emit_ff  <= emit_in;
         end_ff   <= end_in;
         first_ff <= first_in;
         final_ff <= final_in;
      end
   end

endmodule

[rtl/sha256_message_digest_top.sv]
// SHA-256 hash engine fed one message byte per input word.
// The request channel carries a byte, a flag that says whether the byte is
// present, and an end-of-message flag; an end word with no byte is allowed,
// so the empty message can be hashed.
// Bytes are taken one per cycle until a 64-byte block is full.
// The block is then compressed by one round unit, one round per cycle,
// and the result is folded into the chaining value.
// During that time the request channel is not ready. At the end of a
// message the engine inserts the pad byte, zero fill and the bit length
// one byte per cycle, pausing while a block is compressed, and compresses
// one or two final blocks.
// The digest then leaves as eight 32-bit words on the response channel,
// most significant first, the last one flagged.
// No new request is taken until all eight words are taken; a stalled
// receiver holds the current word steady.
// After the last word the chaining value is back at the initial value.
// Reset returns the engine to the start of an empty message.
module sha256_message_digest_top (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sha256md_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sha256md_pkg::rsp_type rsp_data
);
   import sha256md_pkg::*;

   cmd_type cmd;
   sts_type sts;

   sha256md_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   sha256md_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule
